// File: sv/priority_task_scheduler_unit_macros.svh
// assertion macros used by the scheduler rtl
`ifndef PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH

// antecedent holds, consequent holds in the next cycle
`define PST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed: next-cycle property");

// condition never holds outside reset
`define PST_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("scheduler check failed: forbidden condition");

`endif

// File: sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// shared constants, codes and types of the priority task scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

   localparam int MAX_TASKS = 8;
   localparam int TASK_W    = 3;
   localparam int PRIO_W    = 8;
   localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
   localparam int MASK_W    = 8;
   localparam int ACTION_W  = 2;
   localparam int TICK_W    = 32;
   localparam int PRIOS_W   = 64;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 64;

   localparam logic [PRIOS_W-1:0] PRIOS_RESET = PRIOS_W'(1282);
   localparam logic [3:0]         TASKS_RESET = 4'd2;

   localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELAY    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PRIORITIES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASKS      = 1'b1;

   typedef enum logic [1:0] {
      STAT_READY   = 2'd0,
      STAT_RUNNING = 2'd1,
      STAT_BLOCKED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WAKE,
      CELL_DELAY,
      CELL_RELEASE,
      CELL_RUN
   } cell_op_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_SCAN,
      SEQ_COMMIT,
      SEQ_REPORT
   } seq_state_type;

   typedef struct packed {
      cell_op_type         op;
      logic [TASK_W-1:0]   target;
      logic [TICK_W-1:0]   tick;
      logic [TICK_W-1:0]   wake;
      logic [COUNT_W-1:0]  count;
   } cell_ctrl_type;

   typedef struct packed {
      logic              found;
      logic [TASK_W-1:0] task_idx;
      logic [PRIO_W-1:0] prio;
   } cand_type;

endpackage

`default_nettype wire

// File: sv/pst_if.sv
// ----------------------------------------------------------------------------
// pst_req_if / pst_rsp_if
// valid/ready channels for scheduler requests and responses
// ----------------------------------------------------------------------------
`default_nettype none

interface pst_req_if;
   logic                          valid;
   logic                          ready;
   logic [pst_pkg::ACTION_W-1:0]  action;
   logic [pst_pkg::TICK_W-1:0]    now;
   logic [pst_pkg::TICK_W-1:0]    delay_amount;

   modport source (output valid, output action, output now, output delay_amount,
                   input ready);
   modport sink   (input valid, input action, input now, input delay_amount,
                   output ready);
endinterface

interface pst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         selected_valid;
   logic [pst_pkg::TASK_W-1:0]   selected_task;
   logic [pst_pkg::TASK_W-1:0]   running_index;
   logic [pst_pkg::MASK_W-1:0]   ready_mask;
   logic [pst_pkg::MASK_W-1:0]   blocked_mask;

   modport source (output valid, output selected_valid, output selected_task,
                   output running_index, output ready_mask, output blocked_mask,
                   input ready);
   modport sink   (input valid, input selected_valid, input selected_task,
                   input running_index, input ready_mask, input blocked_mask,
                   output ready);
endinterface

`default_nettype wire

// File: sv/pst_task_cell.sv
// ----------------------------------------------------------------------------
// pst_task_cell
// one task slot: status, wake time and one stage of the priority scan chain
// ----------------------------------------------------------------------------
`default_nettype none

module pst_task_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [pst_pkg::TASK_W-1:0]  cell_index,
   input  wire logic [pst_pkg::PRIO_W-1:0]  prio,
   input  wire pst_pkg::cell_ctrl_type      ctrl,
   input  wire pst_pkg::cand_type           cand_in,
   output pst_pkg::cand_type                cand_out,
   output logic                             ready_flag,
   output logic                             blocked_flag
);
   import pst_pkg::*;

   status_type          status_ff, status_in;
   logic [TICK_W-1:0]   wake_ff, wake_in;
   cand_type            cand_ff, cand_in_next;
   logic                in_use;
   logic                targeted;

   assign in_use   = COUNT_W'(cell_index) < ctrl.count;
   assign targeted = in_use && (ctrl.target == cell_index);

   always_comb begin
      status_in = status_ff;
      wake_in   = wake_ff;
      case (ctrl.op)
         CELL_WAKE: begin
            if (in_use && status_ff == STAT_BLOCKED && ctrl.tick >= wake_ff) begin
               status_in = STAT_READY;
            end
         end
         CELL_DELAY: begin
            if (targeted) begin
               status_in = STAT_BLOCKED;
               wake_in   = ctrl.wake;
            end
         end
         CELL_RELEASE: begin
            if (targeted && status_ff == STAT_RUNNING) begin
               status_in = STAT_READY;
            end
         end
         CELL_RUN: begin
            if (targeted) begin
               status_in = STAT_RUNNING;
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   // take over the candidate when ready and strictly better (lower index wins ties)
   always_comb begin
      cand_in_next = cand_in;
      if (ready_flag && (!cand_in.found || prio > cand_in.prio)) begin
         cand_in_next.found    = 1'b1;
         cand_in_next.task_idx = cell_index;
         cand_in_next.prio     = prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= STAT_READY;
         cand_ff.found <= 1'b0;
      end else begin
         status_ff     <= status_in;
         cand_ff.found <= cand_in_next.found;
      end
      wake_ff          <= wake_in;
      cand_ff.task_idx <= cand_in_next.task_idx;
      cand_ff.prio     <= cand_in_next.prio;
   end

   assign cand_out     = cand_ff;
   assign ready_flag   = in_use && status_ff == STAT_READY;
   assign blocked_flag = in_use && status_ff == STAT_BLOCKED;

endmodule

`default_nettype wire

// File: sv/pst_sequencer.sv
// ----------------------------------------------------------------------------
// pst_sequencer
// item sequencing, cell commands, current task and response register
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_task_scheduler_unit_macros.svh"

module pst_sequencer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pst_req_if.sink                            req,
   pst_rsp_if.source                          rsp,
   input  wire logic [pst_pkg::COUNT_W-1:0]   task_count,
   input  wire pst_pkg::cand_type             cand_last,
   input  wire logic [pst_pkg::MAX_TASKS-1:0] ready_vec,
   input  wire logic [pst_pkg::MAX_TASKS-1:0] blocked_vec,
   output pst_pkg::cell_ctrl_type             cell_ctrl
);
   import pst_pkg::*;

   localparam logic [COUNT_W-1:0] SCAN_LAST = COUNT_W'(MAX_TASKS - 1);

   seq_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [ACTION_W-1:0] action_ff;
   logic [TICK_W-1:0]   now_ff;
   logic [TICK_W-1:0]   delay_ff;
   logic [TASK_W-1:0]   current_ff, current_in;
   logic                sel_valid_ff, sel_valid_in;
   logic [TASK_W-1:0]   sel_task_ff, sel_task_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_load;
   logic                accept;

   assign accept   = req.valid && req.ready;
   assign rsp_load = (state_ff == SEQ_REPORT) && (!rsp_valid_ff || rsp.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE:   if (accept) state_in = SEQ_EXEC;
         SEQ_EXEC:   state_in = (action_ff == ACT_SCHEDULE) ? SEQ_SCAN : SEQ_REPORT;
         SEQ_SCAN:   if (scan_cnt_ff == SCAN_LAST) state_in = SEQ_COMMIT;
         SEQ_COMMIT: state_in = SEQ_REPORT;
         SEQ_REPORT: if (rsp_load) state_in = SEQ_IDLE;
         default:    state_in = SEQ_IDLE;
      endcase
   end

   // outputs and cell commands
   always_comb begin
      req.ready        = 1'b0;
      cell_ctrl.op     = CELL_HOLD;
      cell_ctrl.target = current_ff;
      cell_ctrl.tick   = now_ff;
      cell_ctrl.wake   = now_ff + delay_ff;
      cell_ctrl.count  = task_count;
      case (state_ff)
         SEQ_IDLE: begin
            // no word taken while reset is high
            req.ready = !reset;
         end
         SEQ_EXEC: begin
            case (action_ff)
               ACT_SCHEDULE: cell_ctrl.op = CELL_WAKE;
               ACT_DELAY:    cell_ctrl.op = CELL_DELAY;
               ACT_RELEASE:  cell_ctrl.op = CELL_RELEASE;
               default:      cell_ctrl.op = CELL_HOLD;
            endcase
         end
         SEQ_COMMIT: begin
            cell_ctrl.target = cand_last.task_idx;
            if (cand_last.found) cell_ctrl.op = CELL_RUN;
         end
         default: begin
            cell_ctrl.op = CELL_HOLD;
         end
      endcase
   end

   always_comb begin
      scan_cnt_in  = (state_ff == SEQ_SCAN) ? scan_cnt_ff + COUNT_W'(1) : '0;
      current_in   = current_ff;
      sel_valid_in = sel_valid_ff;
      sel_task_in  = sel_task_ff;
      if (state_ff == SEQ_EXEC) begin
         sel_valid_in = 1'b0;
         sel_task_in  = '0;
      end
      if (state_ff == SEQ_COMMIT && cand_last.found) begin
         current_in   = cand_last.task_idx;
         sel_valid_in = 1'b1;
         sel_task_in  = cand_last.task_idx;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         scan_cnt_ff  <= '0;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_valid_ff <= sel_valid_in;
      sel_task_ff  <= sel_task_in;
      if (accept) begin
         action_ff <= req.action;
         now_ff    <= req.now;
         delay_ff  <= req.delay_amount;
      end
      if (rsp_load) begin
         rsp.selected_valid <= sel_valid_ff;
         rsp.selected_task  <= sel_task_ff;
         rsp.running_index  <= current_ff;
         rsp.ready_mask     <= MASK_W'(ready_vec);
         rsp.blocked_mask   <= MASK_W'(blocked_vec);
      end
   end

   assign rsp.valid = rsp_valid_ff;

   `PST_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == SEQ_EXEC)
   `PST_ASSERT_NEXT(a_scan_commit, clock, reset,
      state_ff == SEQ_SCAN && scan_cnt_ff == SCAN_LAST, state_ff == SEQ_COMMIT)
   `PST_ASSERT_NEXT(a_commit_current, clock, reset,
      state_ff == SEQ_COMMIT && cand_last.found,
      current_ff == $past(cand_last.task_idx) && sel_valid_ff)
   `PST_ASSERT_NEVER(a_masks_disjoint, clock, reset, (ready_vec & blocked_vec) != '0)

endmodule

`default_nettype wire

// File: sv/priority_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_unit
// fixed-priority task scheduler with timed delay, built as a row of task cells
// ----------------------------------------------------------------------------
// usage:
//   req_ch carries one word per kernel event: action (schedule, delay,
//   release), the current tick and the delay amount. rsp_ch returns one word
//   per request: selection, current task and ready/blocked masks.
//   csr_we/csr_index/csr_wdata write task priorities (index 0) and the task
//   count (index 1); write only while no request is in flight.
// sequencing:
//   delay and release: the exec state drives the cell command, then the
//   report state loads the response register. schedule: wake pass, then
//   the best candidate ripples through the chain one cell per cycle, then
//   commit and report. a new request is taken only once the previous word
//   has been loaded into the response register.
// reset: all tasks ready, current task 0, priorities 0x0502, two tasks.
// stall: the response register holds a word while rsp_ch.ready is low; the
//   next request is still taken and waits for the register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pst_req_if.sink                            req_ch,
   pst_rsp_if.source                          rsp_ch,
   input  wire logic                          csr_we,
   input  wire logic [pst_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pst_pkg::CSR_W-1:0]     csr_wdata
);
   import pst_pkg::*;

   // configuration registers
   logic [PRIOS_W-1:0]  prios_ff, prios_in;
   logic [3:0]          tasks_ff, tasks_in;
   logic [COUNT_W-1:0]  task_count;

   // chain wiring: entry 0 is an empty candidate
   cand_type            cand_chain [MAX_TASKS+1];
   cell_ctrl_type       cell_ctrl;
   logic [MAX_TASKS-1:0] ready_vec;
   logic [MAX_TASKS-1:0] blocked_vec;

   always_comb begin
      prios_in = prios_ff;
      tasks_in = tasks_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PRIORITIES: prios_in = csr_wdata[PRIOS_W-1:0];
            CSR_TASKS:      tasks_in = csr_wdata[3:0];
            default:        prios_in = prios_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prios_ff <= PRIOS_RESET;
         tasks_ff <= TASKS_RESET;
      end else begin
         prios_ff <= prios_in;
         tasks_ff <= tasks_in;
      end
   end

   // counts above the cell count saturate
   assign task_count = (tasks_ff > 4'(MAX_TASKS)) ? COUNT_W'(MAX_TASKS)
                                                  : COUNT_W'(tasks_ff);

   assign cand_chain[0] = '0;

   // one cell per task, candidate handed to the next cell every cycle
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      pst_task_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (TASK_W'(i)),
         .prio         (prios_ff[i*PRIO_W +: PRIO_W]),
         .ctrl         (cell_ctrl),
         .cand_in      (cand_chain[i]),
         .cand_out     (cand_chain[i+1]),
         .ready_flag   (ready_vec[i]),
         .blocked_flag (blocked_vec[i])
      );
   end

   pst_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .task_count  (task_count),
      .cand_last   (cand_chain[MAX_TASKS]),
      .ready_vec   (ready_vec),
      .blocked_vec (blocked_vec),
      .cell_ctrl   (cell_ctrl)
   );

endmodule

`default_nettype wire

// File: tb/sv/pst_sched_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_sched_monitor
// watches the scheduler channels and register writes, keeps its own copy of
// task status, wake times, current task and settings, and compares every
// response word against the word it predicts for the matching request
// ----------------------------------------------------------------------------

module pst_sched_monitor (
   input  logic                          clock,
   input  logic                          reset,
   pst_req_if                            req_ch,
   pst_rsp_if                            rsp_ch,
   input  logic                          csr_we,
   input  logic [pst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pst_pkg::CSR_W-1:0]     csr_wdata,
   output int                            outstanding,
   output int                            fail_count,
   output int                            word_count,
   output int                            pick_count
);
   import pst_pkg::*;

   typedef struct packed {
      logic               sel_valid;
      logic [TASK_W-1:0]  sel_task;
      logic [TASK_W-1:0]  run_idx;
      logic [MASK_W-1:0]  ready_bits;
      logic [MASK_W-1:0]  blocked_bits;
   } sched_report_type;

   logic [PRIOS_W-1:0] prio_cfg;
   logic [3:0]         count_cfg;
   status_type         task_stat [MAX_TASKS];
   logic [TICK_W-1:0]  wake_at [MAX_TASKS];
   logic [TASK_W-1:0]  cur_task;
   sched_report_type   pending_reports [$];
   int                 rsp_seen;

   // advance the task table by one request word and return the report it gives
   function automatic sched_report_type apply_event(input logic [ACTION_W-1:0] act,
                                                    input logic [TICK_W-1:0] tick,
                                                    input logic [TICK_W-1:0] ticks_off);
      sched_report_type  rep;
      int                active;
      logic              found;
      logic [TASK_W-1:0] best;
      logic [PRIO_W-1:0] best_prio;
      rep       = '0;
      found     = 1'b0;
      best      = '0;
      best_prio = '0;
      active    = (count_cfg > MAX_TASKS) ? MAX_TASKS : int'(count_cfg);
      case (act)
         ACT_SCHEDULE: begin
            for (int t = 0; t < active; t++)
               if (task_stat[t] == STAT_BLOCKED && tick >= wake_at[t])
                  task_stat[t] = STAT_READY;
            for (int t = 0; t < active; t++)
               if (task_stat[t] == STAT_READY &&
                   (!found || prio_cfg[PRIO_W*t +: PRIO_W] > best_prio)) begin
                  found     = 1'b1;
                  best      = TASK_W'(t);
                  best_prio = prio_cfg[PRIO_W*t +: PRIO_W];
               end
            if (found) begin
               cur_task        = best;
               task_stat[best] = STAT_RUNNING;
               rep.sel_valid   = 1'b1;
               rep.sel_task    = best;
            end
         end
         ACT_DELAY: begin
            if (int'(cur_task) < active) begin
               wake_at[cur_task]   = tick + ticks_off;
               task_stat[cur_task] = STAT_BLOCKED;
            end
         end
         ACT_RELEASE: begin
            if (int'(cur_task) < active && task_stat[cur_task] == STAT_RUNNING)
               task_stat[cur_task] = STAT_READY;
         end
         default: ;
      endcase
      rep.run_idx = cur_task;
      for (int t = 0; t < active; t++) begin
         if (task_stat[t] == STAT_READY)
            rep.ready_bits[t] = 1'b1;
         else if (task_stat[t] == STAT_BLOCKED)
            rep.blocked_bits[t] = 1'b1;
      end
      return rep;
   endfunction

   always @(posedge clock) begin : track
      sched_report_type got;
      sched_report_type want;
      if (reset) begin
         prio_cfg  = PRIOS_RESET;
         count_cfg = TASKS_RESET;
         foreach (task_stat[t]) begin
            task_stat[t] = STAT_READY;
            wake_at[t]   = '0;
         end
         cur_task   = '0;
         pending_reports.delete();
         rsp_seen   = 0;
         fail_count = 0;
         word_count = 0;
         pick_count = 0;
      end else begin
         if (csr_we)
            case (csr_index)
               CSR_PRIORITIES: prio_cfg  = csr_wdata[PRIOS_W-1:0];
               CSR_TASKS:      count_cfg = csr_wdata[3:0];
               default:        ;
            endcase
         if (req_ch.valid && req_ch.ready) begin
            pending_reports.push_back(apply_event(req_ch.action, req_ch.now,
                                                  req_ch.delay_amount));
            word_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.sel_valid    = rsp_ch.selected_valid;
            got.sel_task     = rsp_ch.selected_task;
            got.run_idx      = rsp_ch.running_index;
            got.ready_bits   = rsp_ch.ready_mask;
            got.blocked_bits = rsp_ch.blocked_mask;
            if (pending_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("response word %0d arrived with nothing outstanding", rsp_seen);
            end else begin
               want = pending_reports.pop_front();
               if (want.sel_valid == 1'b1)
                  pick_count++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"word %0d mismatch: expected sel %b task %0d run %0d ",
                               "ready %b blocked %b, got sel %b task %0d run %0d ",
                               "ready %b blocked %b"},
                              rsp_seen, want.sel_valid, want.sel_task, want.run_idx,
                              want.ready_bits, want.blocked_bits, got.sel_valid,
                              got.sel_task, got.run_idx, got.ready_bits,
                              got.blocked_bits);
               end
            end
            rsp_seen++;
         end
      end
      outstanding <= pending_reports.size();
   end

endmodule

// File: tb/sv/tb_priority_task_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_task_scheduler_unit
// self-checking bench for the priority task scheduler: a directed opening
// walks reset values, wake timing, tick wrap, ties and odd task counts, then
// randomized phases drive tick-ordered schedule/delay/release traffic under
// many priority and task-count settings with random gaps and response stalls
// ----------------------------------------------------------------------------

module tb_priority_task_scheduler_unit;
   import pst_pkg::*;

   // action code the block has no meaning for
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 7;
   localparam int WATCHDOG_LIMIT  = 2000;
   // settle time after the drain, longer than a schedule word takes
   localparam int SETTLE_CYCLES   = 2 * MAX_TASKS + 8;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 125;
   localparam int GAP_PERCENT     = 9;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   // set during one random phase to run both sides without any gaps
   bit                   no_gaps = 1'b0;
   logic [TICK_W-1:0]    tick_now;
   int                   settings_used = 0;
   int                   quiet_cycles = 0;
   int                   outstanding;
   int                   fail_count;
   int                   word_count;
   int                   pick_count;

   pst_req_if req_ch ();
   pst_rsp_if rsp_ch ();

   priority_task_scheduler_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pst_sched_monitor i_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count),
      .word_count  (word_count),
      .pick_count  (pick_count)
   );

   always #CLK_HALF clock = ~clock;

   // every input known from time zero
   initial begin
      csr_we              = 1'b0;
      csr_index           = CSR_PRIORITIES;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_SCHEDULE;
      req_ch.now          = '0;
      req_ch.delay_amount = '0;
      rsp_ch.ready        = 1'b0;
   end

   // response side: random stalls, none while no_gaps is set
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && (no_gaps || $urandom_range(99) >= GAP_PERCENT);
   end

   // watchdog on cycles where neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no channel activity for %0d cycles", WATCHDOG_LIMIT);
         $display("priority_task_scheduler_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one request word and hold it until taken; valid stays high so
   // back-to-back words need no second assignment in the same step
   task automatic issue_event(input logic [ACTION_W-1:0] act,
                              input logic [TICK_W-1:0]   tick,
                              input logic [TICK_W-1:0]   ticks_off);
      while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.now          <= tick;
      req_ch.delay_amount <= ticks_off;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // drop valid and wait until every predicted word has come back
   task automatic settle_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // both registers on back-to-back cycles, block idle
   task automatic load_settings(input logic [PRIOS_W-1:0] prios, input logic [3:0] count);
      csr_we    <= 1'b1;
      csr_index <= CSR_PRIORITIES;
      csr_wdata <= CSR_W'(prios);
      @(posedge clock);
      csr_index <= CSR_TASKS;
      csr_wdata <= CSR_W'(count);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      logic [PRIOS_W-1:0] prios;
      logic [3:0]         count;
      int                 roll;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: task 1 outranks task 0, two tasks in use
      issue_event(ACT_SCHEDULE, 32'd0, 32'd0);
      issue_event(ACT_RELEASE, 32'd1, 32'd0);
      issue_event(ACT_SCHEDULE, 32'd2, 32'd0);
      issue_event(ACT_DELAY, 32'd100, 32'd50);
      issue_event(ACT_SCHEDULE, 32'd120, 32'd0);
      // one tick early: nothing ready, current task kept
      issue_event(ACT_SCHEDULE, 32'd149, 32'd0);
      // wake exactly at the stored time, old task stays running
      issue_event(ACT_SCHEDULE, 32'd150, 32'd0);
      // wake time wraps past the top of the tick range
      issue_event(ACT_DELAY, 32'hFFFF_FFF0, 32'h0000_0020);
      issue_event(ACT_SCHEDULE, 32'hFFFF_FFFF, 32'd0);
      issue_event(ACT_DELAY, 32'd0, 32'hFFFF_FFFF);
      issue_event(ACT_SCHEDULE, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      issue_event(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // release of a blocked task does nothing
      issue_event(ACT_RELEASE, 32'd7, 32'd0);
      // delay of an already blocked task rewrites its wake time
      issue_event(ACT_DELAY, 32'd5, 32'd0);
      issue_event(ACT_SCHEDULE, 32'd5, 32'd0);

      // all priorities equal: lowest ready index wins
      settle_idle();
      load_settings('0, 4'd8);
      issue_event(ACT_SCHEDULE, 32'd0, 32'd0);
      issue_event(ACT_RELEASE, 32'd1, 32'd0);
      issue_event(ACT_SCHEDULE, 32'd2, 32'd0);

      // count above the task limit acts as the limit, top task highest
      settle_idle();
      load_settings(64'hFF00_0000_0000_0000, 4'd15);
      issue_event(ACT_SCHEDULE, 32'd3, 32'd0);
      issue_event(ACT_DELAY, 32'd10, 32'd1);

      // one task left: current task is out of range now
      settle_idle();
      load_settings('1, 4'd1);
      issue_event(ACT_DELAY, 32'd12, 32'd3);
      issue_event(ACT_RELEASE, 32'd13, 32'd0);
      issue_event(ACT_SCHEDULE, 32'd20, 32'd0);

      // no task in use: every action is a no-op
      settle_idle();
      load_settings(64'h0102_0304_0506_0708, 4'd0);
      issue_event(ACT_SCHEDULE, 32'hFFFF_FFFF, 32'd0);
      issue_event(ACT_DELAY, 32'd0, 32'd9);
      issue_event(ACT_RELEASE, 32'd0, 32'd0);

      // random phases: mostly tick-ordered kernel traffic with short delays so
      // tasks cycle through blocked and ready, plus wild ticks and junk codes
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         for (int b = 0; b < MAX_TASKS; b++)
            prios[PRIO_W*b +: PRIO_W] = (ph % 2 == 0) ? PRIO_W'($urandom_range(3))
                                                      : PRIO_W'($urandom);
         if (ph == 0)
            count = 4'd8;
         else if (ph == RANDOM_PHASES - 1)
            count = 4'd1;
         else if (ph == 5)
            count = 4'($urandom_range(9, 15));
         else
            count = 4'($urandom_range(1, 8));
         settle_idle();
         load_settings(prios, count);
         no_gaps  = (ph == 3);
         tick_now = $urandom;
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            roll     = $urandom_range(99);
            tick_now = tick_now + $urandom_range(0, 6);
            if (roll < 45)
               issue_event(ACT_SCHEDULE, tick_now, $urandom);
            else if (roll < 75)
               issue_event(ACT_DELAY, tick_now,
                           ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 24));
            else if (roll < 90)
               issue_event(ACT_RELEASE, tick_now, $urandom);
            else if (roll < 95)
               issue_event(ACT_UNUSED, $urandom, $urandom);
            else
               // out-of-order tick, may wake long-parked tasks
               issue_event(ACT_SCHEDULE, $urandom, $urandom);
         end
      end
      no_gaps = 1'b0;

      // drain, then leave time for any stray word to show up
      settle_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("ran %0d request words, %0d of them schedule picks, under %0d register settings",
               word_count, pick_count, settings_used);
      $display("including tick wrap, task counts from 0 to 15, tied and extreme priorities");
      if (fail_count == 0) begin
         $display("priority_task_scheduler_unit regression: pass");
      end else begin
         $display("%0d mismatching words", fail_count);
         $display("priority_task_scheduler_unit regression: fail");
      end
      $finish;
   end

endmodule
